>>> src/hde_pkg.sv
// ----------------------------------------------------------------------------
// hde_pkg: shared types and constants of the horner derivative evaluator
// fixed-point widths, sequencer states, cell control word and register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package hde_pkg;

   // fixed-point widths, all two's complement with 16 fraction bits
   localparam int COEF_W  = 32;
   localparam int ACC_W   = 64;
   localparam int OPND_W  = 48;
   localparam int PSUM_W  = 112;
   localparam int TERM_W  = 71;
   localparam int ORD_W   = 3;
   localparam int PHASE_W = 3;
   localparam int CSR_IDX_W = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DERIVATIVE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SCALE      = 4'd1;

   localparam logic [ORD_W-1:0] MAX_DERIVATIVE_RST = 3'd0;
   localparam logic [31:0]      INV_SCALE_RST      = 32'h0001_0000;

   // phases of one multiply-accumulate pass inside a cell
   localparam logic [PHASE_W-1:0] PH_LOAD      = 3'd0;
   localparam logic [PHASE_W-1:0] PH_MUL_FIRST = 3'd1;
   localparam logic [PHASE_W-1:0] PH_MUL_LAST  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_SUM_FIRST = 3'd2;
   localparam logic [PHASE_W-1:0] PH_SUM_LAST  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_ROUND     = 3'd6;
   localparam logic [PHASE_W-1:0] PH_COMMIT    = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POINT_MUL,
      ST_POINT_RND,
      ST_STEP,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CM_HOLD,
      CM_CLEAR,
      CM_HORNER,
      CM_SCALE,
      CM_SHIFT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type        mode;
      logic [PHASE_W-1:0]   phase;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> src/hde_cell.sv
// ----------------------------------------------------------------------------
// hde_cell: one derivative level of the horner chain
// holds one accumulator, runs a four-pass 32x32 q16 multiply, adds the scaled
// lower neighbor, and shifts toward the output end during emission
// ----------------------------------------------------------------------------
`default_nettype none

module hde_cell #(
   parameter int CELL_ORDER = 0
) (
   input  wire logic                                   clock,
   input  wire hde_pkg::cell_ctl_type                  ctl,
   input  wire logic                                   enable,
   input  wire logic signed [hde_pkg::OPND_W-1:0]      mul_operand,
   input  wire logic signed [hde_pkg::ACC_W-1:0]       lower_acc,
   input  wire logic signed [hde_pkg::ACC_W-1:0]       upper_acc,
   output      logic signed [hde_pkg::ACC_W-1:0]       acc
);

   // cell 0 adds the coefficient once, cell d adds d times its lower neighbor
   localparam logic signed [6:0] FACTOR = (CELL_ORDER == 0) ? 7'sd1 : 7'(CELL_ORDER);

   logic signed [hde_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [hde_pkg::ACC_W-1:0]         xmag_ff, xmag_in;
   logic [hde_pkg::OPND_W-1:0]        ymag_ff, ymag_in;
   logic                              neg_ff, neg_in;
   logic signed [hde_pkg::TERM_W-1:0] term_ff, term_in;
   logic [63:0]                       prod_ff, prod_in;
   logic [1:0]                        prod_sel_ff, prod_sel_in;
   logic [hde_pkg::PSUM_W-1:0]        psum_ff, psum_in;
   logic signed [hde_pkg::ACC_W-1:0]  mres_ff, mres_in;

   logic [1:0]                        sel;
   logic [31:0]                       xs, ys;
   logic [hde_pkg::PSUM_W-1:0]        shifted;
   logic [hde_pkg::PSUM_W-1:0]        rnd;
   logic [95:0]                       rmag;
   logic [63:0]                       lim, sat_mag;
   logic signed [71:0]                sum;
   logic signed [hde_pkg::ACC_W-1:0]  sum_sat;
   logic                              busy;

   assign acc = acc_ff;
   assign busy = (ctl.mode == hde_pkg::CM_HORNER) || (ctl.mode == hde_pkg::CM_SCALE);

   // partial product select: bit 1 picks the high half of x, bit 0 of y
   assign sel = 2'(ctl.phase - hde_pkg::PH_MUL_FIRST);
   assign xs  = sel[1] ? xmag_ff[63:32] : xmag_ff[31:0];
   assign ys  = sel[0] ? {16'b0, ymag_ff[47:32]} : ymag_ff[31:0];
   assign prod_in = xs * ys;

   always_comb begin
      unique case (prod_sel_ff)
         2'b00:   shifted = {48'b0, prod_ff};
         2'b01:   shifted = {16'b0, prod_ff, 32'b0};
         2'b10:   shifted = {16'b0, prod_ff, 32'b0};
         default: shifted = {prod_ff[47:0], 64'b0};
      endcase
   end

   // round half away from zero on the magnitude, then clamp to signed 64
   assign rnd     = psum_ff + 112'h8000;
   assign rmag    = rnd[111:16];
   assign lim     = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
   assign sat_mag = ((|rmag[95:64]) || (rmag[63:0] > lim)) ? lim : rmag[63:0];

   assign term_in = $signed({{7{lower_acc[63]}}, lower_acc}) * FACTOR;

   assign sum = {{8{mres_ff[63]}}, mres_ff} + {term_ff[70], term_ff};
   always_comb begin
      if ((&sum[71:63]) || !(|sum[71:63])) begin
         sum_sat = sum[63:0];
      end else if (sum[71]) begin
         sum_sat = 64'sh8000_0000_0000_0000;
      end else begin
         sum_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
      end
   end

   always_comb begin
      acc_in      = acc_ff;
      xmag_in     = xmag_ff;
      ymag_in     = ymag_ff;
      neg_in      = neg_ff;
      prod_sel_in = prod_sel_ff;
      psum_in     = psum_ff;
      mres_in     = mres_ff;

      if (ctl.mode == hde_pkg::CM_CLEAR) begin
         acc_in = '0;
      end else if (ctl.mode == hde_pkg::CM_SHIFT) begin
         acc_in = upper_acc;
      end else if (busy) begin
         if (ctl.phase == hde_pkg::PH_LOAD) begin
            xmag_in = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
            ymag_in = mul_operand[47] ? 48'(-mul_operand) : 48'(mul_operand);
            neg_in  = acc_ff[63] ^ mul_operand[47];
            psum_in = '0;
         end
         if (ctl.phase >= hde_pkg::PH_MUL_FIRST && ctl.phase <= hde_pkg::PH_MUL_LAST) begin
            prod_sel_in = sel;
         end
         if (ctl.phase >= hde_pkg::PH_SUM_FIRST && ctl.phase <= hde_pkg::PH_SUM_LAST) begin
            psum_in = psum_ff + shifted;
         end
         if (ctl.phase == hde_pkg::PH_ROUND) begin
            mres_in = neg_ff ? 64'(-sat_mag) : 64'(sat_mag);
         end
         if (ctl.phase == hde_pkg::PH_COMMIT && enable) begin
            acc_in = (ctl.mode == hde_pkg::CM_HORNER) ? sum_sat : mres_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      xmag_ff     <= xmag_in;
      ymag_ff     <= ymag_in;
      neg_ff      <= neg_in;
      prod_sel_ff <= prod_sel_in;
      psum_ff     <= psum_in;
      mres_ff     <= mres_in;
      if (busy && ctl.phase == hde_pkg::PH_LOAD) begin
         term_ff <= term_in;
      end
      if (busy && ctl.phase >= hde_pkg::PH_MUL_FIRST && ctl.phase <= hde_pkg::PH_MUL_LAST) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

>>> src/horner_derivative_evaluator_core.sv
// ----------------------------------------------------------------------------
// horner_derivative_evaluator_core: polynomial value and derivatives by horner
// a chain of cells, one per derivative level, takes one coefficient per pass
// ----------------------------------------------------------------------------
// flow: each coefficient transfer runs one horner pass; the first of a run
//   also forms the scaled point before its pass; each cell runs its q16 multiply
//   as four 32x32 partial products plus load, round and commit phases
// after the last coefficient: one inv_scale pass per order, then one
//   result per cycle (order + 1 results) as the rsp side takes them
// reset: synchronous; clears sequencer, handshakes and the run flag and loads
//   register defaults; accumulators are cleared at the start of every run
`default_nettype none

module horner_derivative_evaluator_core #(
   parameter int MAX_ORDER = 7
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input stream
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [63:0]                        req_tdata,   // coefficient, point
   input  wire logic                               req_tlast,   // last_coef
   // result stream
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [31:0]                        rsp_tdata,   // derivative_value
   output      logic [hde_pkg::ORD_W-1:0]          rsp_tuser,   // derivative_order
   output      logic                               rsp_tlast,   // last
   // register writes
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [hde_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [31:0]                        csr_data
);

   localparam int NUM_CELLS = MAX_ORDER + 1;

   // registers
   logic [hde_pkg::ORD_W-1:0]  max_deriv_ff;
   logic [31:0]                inv_scale_ff;

   // sequencer
   hde_pkg::state_type          state_ff, state_in;
   logic [hde_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [hde_pkg::ORD_W-1:0]   round_ff, round_in;
   logic [hde_pkg::ORD_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic [hde_pkg::ORD_W-1:0]   emit_top_ff, emit_top_in;
   logic                        run_started_ff, run_started_in;

   // latched input item
   logic signed [31:0]          coef_ff, coef_in;
   logic signed [31:0]          point_ff, point_in;
   logic                        last_ff, last_in;

   // scaled point
   logic [63:0]                 pprod_ff, pprod_in;
   logic                        pneg_ff, pneg_in;
   logic signed [hde_pkg::OPND_W-1:0] sp_ff, sp_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_data_ff, rsp_data_in;
   logic [hde_pkg::ORD_W-1:0]   rsp_order_ff, rsp_order_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [hde_pkg::ORD_W-1:0]   top_order;
   logic                        rsp_load;
   logic [31:0]                 point_mag;
   logic [64:0]                 prnd;
   logic [hde_pkg::OPND_W-1:0]  pm;
   logic [31:0]                 acc0_sat;
   logic signed [hde_pkg::OPND_W-1:0] mul_operand;
   hde_pkg::cell_ctl_type       cell_ctl;
   logic [NUM_CELLS-1:0]        cell_en;
   logic signed [hde_pkg::ACC_W-1:0] cell_acc [NUM_CELLS];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == hde_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_order_ff;
   assign rsp_tlast  = rsp_last_ff;

   // highest order in use, limited by the number of cells
   assign top_order = (32'(max_deriv_ff) > MAX_ORDER) ? 3'(MAX_ORDER) : max_deriv_ff;

   // config write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         max_deriv_ff <= hde_pkg::MAX_DERIVATIVE_RST;
         inv_scale_ff <= hde_pkg::INV_SCALE_RST;
      end else if (csr_valid) begin
         if (csr_index == hde_pkg::REG_MAX_DERIVATIVE) begin
            max_deriv_ff <= csr_data[hde_pkg::ORD_W-1:0];
         end else if (csr_index == hde_pkg::REG_INV_SCALE) begin
            inv_scale_ff <= csr_data;
         end
      end
   end

   // scaled point = round(point * inv_scale / 2^16), always fits in 48 bits
   assign point_mag = point_ff[31] ? 32'(-point_ff) : 32'(point_ff);
   assign pprod_in  = point_mag * inv_scale_ff;
   assign pneg_in   = point_ff[31];
   assign prnd      = {1'b0, pprod_ff} + 65'h8000;
   assign pm        = prnd[63:16];

   // accumulator 0 clamped to 32 bits for the result
   always_comb begin
      if ((&cell_acc[0][63:31]) || !(|cell_acc[0][63:31])) begin
         acc0_sat = cell_acc[0][31:0];
      end else if (cell_acc[0][63]) begin
         acc0_sat = 32'h8000_0000;
      end else begin
         acc0_sat = 32'h7FFF_FFFF;
      end
   end

   // horner passes multiply by the scaled point, output passes by inv_scale
   assign mul_operand = (state_ff == hde_pkg::ST_SCALE) ?
                        $signed({16'b0, inv_scale_ff}) : sp_ff;

   assign rsp_load = (state_ff == hde_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      round_in       = round_ff;
      emit_cnt_in    = emit_cnt_ff;
      emit_top_in    = emit_top_ff;
      run_started_in = run_started_ff;
      coef_in        = coef_ff;
      point_in       = point_ff;
      last_in        = last_ff;
      sp_in          = sp_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_order_in   = rsp_order_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      cell_ctl.mode  = hde_pkg::CM_HOLD;
      cell_ctl.phase = phase_ff;

      unique case (state_ff)
         hde_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               coef_in  = req_tdata[31:0];
               point_in = req_tdata[63:32];
               last_in  = req_tlast;
               phase_in = hde_pkg::PH_LOAD;
               state_in = run_started_ff ? hde_pkg::ST_STEP : hde_pkg::ST_POINT_MUL;
            end
         end
         hde_pkg::ST_POINT_MUL: begin
            state_in = hde_pkg::ST_POINT_RND;
         end
         hde_pkg::ST_POINT_RND: begin
            // run start: clear every level and fix the scaled point
            sp_in          = pneg_ff ? 48'(-pm) : 48'(pm);
            run_started_in = 1'b1;
            cell_ctl.mode  = hde_pkg::CM_CLEAR;
            phase_in       = hde_pkg::PH_LOAD;
            state_in       = hde_pkg::ST_STEP;
         end
         hde_pkg::ST_STEP: begin
            cell_ctl.mode = hde_pkg::CM_HORNER;
            phase_in      = 3'(phase_ff + 3'd1);
            if (phase_ff == hde_pkg::PH_COMMIT) begin
               phase_in = hde_pkg::PH_LOAD;
               if (last_ff) begin
                  run_started_in = 1'b0;
                  emit_top_in    = top_order;
                  round_in       = '0;
                  emit_cnt_in    = '0;
                  state_in       = (top_order == '0) ? hde_pkg::ST_EMIT : hde_pkg::ST_SCALE;
               end else begin
                  state_in = hde_pkg::ST_IDLE;
               end
            end
         end
         hde_pkg::ST_SCALE: begin
            // pass r scales every level above r once more
            cell_ctl.mode = hde_pkg::CM_SCALE;
            phase_in      = 3'(phase_ff + 3'd1);
            if (phase_ff == hde_pkg::PH_COMMIT) begin
               phase_in = hde_pkg::PH_LOAD;
               round_in = 3'(round_ff + 3'd1);
               if (3'(round_ff + 3'd1) == emit_top_ff) begin
                  state_in = hde_pkg::ST_EMIT;
               end
            end
         end
         hde_pkg::ST_EMIT: begin
            // level 0 goes out, the chain shifts one level down
            if (rsp_load) begin
               cell_ctl.mode = hde_pkg::CM_SHIFT;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = acc0_sat;
               rsp_order_in  = emit_cnt_ff;
               rsp_last_in   = (emit_cnt_ff == emit_top_ff);
               emit_cnt_in   = 3'(emit_cnt_ff + 3'd1);
               if (emit_cnt_ff == emit_top_ff) begin
                  state_in = hde_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = hde_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= hde_pkg::ST_IDLE;
         phase_ff       <= hde_pkg::PH_LOAD;
         round_ff       <= '0;
         emit_cnt_ff    <= '0;
         emit_top_ff    <= '0;
         run_started_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         round_ff       <= round_in;
         emit_cnt_ff    <= emit_cnt_in;
         emit_top_ff    <= emit_top_in;
         run_started_ff <= run_started_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      coef_ff      <= coef_in;
      point_ff     <= point_in;
      last_ff      <= last_in;
      pprod_ff     <= pprod_in;
      pneg_ff      <= pneg_in;
      sp_ff        <= sp_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_order_ff <= rsp_order_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // chain of cells, level i talks to levels i-1 and i+1
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic signed [hde_pkg::ACC_W-1:0] lower;
      logic signed [hde_pkg::ACC_W-1:0] upper;

      assign cell_en[i] = ((state_ff == hde_pkg::ST_STEP) && (i <= int'(top_order))) ||
                          ((state_ff == hde_pkg::ST_SCALE) && (i > int'(round_ff)));

      if (i == 0) begin : g_first
         assign lower = {{32{coef_ff[31]}}, coef_ff};
      end else begin : g_inner
         assign lower = cell_acc[i-1];
      end

      if (i == MAX_ORDER) begin : g_end
         assign upper = '0;
      end else begin : g_mid
         assign upper = cell_acc[i+1];
      end

      hde_cell #(
         .CELL_ORDER (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .enable      (cell_en[i]),
         .mul_operand (mul_operand),
         .lower_acc   (lower),
         .upper_acc   (upper),
         .acc         (cell_acc[i])
      );
   end

   // the run flag drops exactly when the last coefficient commits
   a_last_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hde_pkg::ST_STEP && phase_ff == hde_pkg::PH_COMMIT && last_ff) |=>
      (!run_started_ff && (state_ff == hde_pkg::ST_SCALE || state_ff == hde_pkg::ST_EMIT)))
      else $error("last coefficient did not end the run");

   // output scaling never runs past the latched order
   a_scale_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hde_pkg::ST_SCALE) |-> (round_ff < emit_top_ff))
      else $error("scale pass beyond order");

   // a new result only comes out of the emission state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == hde_pkg::ST_EMIT))
      else $error("result loaded outside emission");

   // horner steps only run inside a started run
   a_step_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hde_pkg::ST_STEP) |-> run_started_ff)
      else $error("horner step without run start");

endmodule

`default_nettype wire

>>> tb/hde_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hde_tb_pkg: scoreboard for the horner derivative evaluator testbench
// keeps its own copy of registers and accumulators, works out the scaled
// derivatives of every finished polynomial and checks results in order
// ----------------------------------------------------------------------------

package hde_tb_pkg;

   typedef struct packed {
      logic [31:0]              value;
      logic [hde_pkg::ORD_W-1:0] order;
      logic                     last;
   } derivative_type;

   class horner_scoreboard;

      logic signed [63:0]        acc [8];
      logic signed [63:0]        scaled_point;
      bit                        run_open;
      logic [hde_pkg::ORD_W-1:0] max_derivative;
      logic [31:0]               inv_scale;
      derivative_type            expected_derivs [$];
      int                        errors;

      function new();
         foreach (acc[i]) acc[i] = '0;
         scaled_point   = '0;
         run_open       = 1'b0;
         max_derivative = hde_pkg::MAX_DERIVATIVE_RST;
         inv_scale      = hde_pkg::INV_SCALE_RST;
         errors         = 0;
      endfunction

      function int pending();
         return expected_derivs.size();
      endfunction

      // q16 product, rounded half away from zero, clamped to 64 bits
      function logic signed [63:0] q16_mul(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [127:0] wa, wb, prod;
         logic [127:0]        mag, rnd;
         wa   = a;
         wb   = b;
         prod = wa * wb;
         mag  = prod[127] ? -prod : prod;
         rnd  = (mag + 128'h8000) >> 16;
         if (prod[127]) begin
            if (rnd > 128'h8000_0000_0000_0000)
               rnd = 128'h8000_0000_0000_0000;
            return -rnd[63:0];
         end
         if (rnd > 128'h7FFF_FFFF_FFFF_FFFF)
            rnd = 128'h7FFF_FFFF_FFFF_FFFF;
         return rnd[63:0];
      endfunction

      function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [64:0] s;
         s = a;
         s = s + b;
         if (s[64] != s[63])
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         return s[63:0];
      endfunction

      function void write_register(logic [hde_pkg::CSR_IDX_W-1:0] index, logic [31:0] data);
         case (index)
            hde_pkg::REG_MAX_DERIVATIVE: max_derivative = data[hde_pkg::ORD_W-1:0];
            hde_pkg::REG_INV_SCALE:      inv_scale = data;
            default: ;
         endcase
      endfunction

      // one horner step over every order up to max_derivative; the closing coefficient queues results
      function void take_coefficient(logic [31:0] coef, logic [31:0] point, logic last_coef);
         logic signed [63:0] c64, p64, scale64, t, v;
         derivative_type     r;
         int                 d, k;
         c64     = $signed(coef);
         p64     = $signed(point);
         scale64 = {32'd0, inv_scale};
         if (!run_open) begin
            foreach (acc[i]) acc[i] = '0;
            scaled_point = q16_mul(p64, scale64);
            run_open     = 1'b1;
         end
         for (d = max_derivative; d >= 1; d--) begin
            t = q16_mul(acc[d], scaled_point);
            for (k = 0; k < d; k++)
               t = sat_add(t, acc[d-1]);
            acc[d] = t;
         end
         acc[0] = sat_add(q16_mul(acc[0], scaled_point), c64);
         if (!last_coef)
            return;
         run_open = 1'b0;
         for (d = 0; d <= max_derivative; d++) begin
            v = acc[d];
            for (k = 0; k < d; k++)
               v = q16_mul(v, scale64);
            if (v > 64'sd2147483647)
               v = 64'sd2147483647;
            else if (v < -64'sd2147483648)
               v = -64'sd2147483648;
            r.value = v[31:0];
            r.order = hde_pkg::ORD_W'(d);
            r.last  = (d == max_derivative);
            expected_derivs.push_back(r);
         end
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_derivative(logic [31:0] value, logic [hde_pkg::ORD_W-1:0] order, logic last);
         derivative_type want;
         if (expected_derivs.size() == 0) begin
            report($sformatf("result with nothing expected: value %h order %0d", value, order));
            return;
         end
         want = expected_derivs.pop_front();
         if (value !== want.value)
            report($sformatf("order %0d value %h, expected %h", want.order, value, want.value));
         if (order !== want.order)
            report($sformatf("order %0d, expected %0d", order, want.order));
         if (last !== want.last)
            report($sformatf("order %0d last %b, expected %b", want.order, last, want.last));
      endtask

   endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the horner derivative evaluator core
// streams directed and random polynomials under several register settings,
// stalls both sides at random and compares every result with the scoreboard
// ----------------------------------------------------------------------------

module tb_top;

   localparam logic [hde_pkg::CSR_IDX_W-1:0] REG_SPARE = 4'd9;   // not a register, write is dropped
   localparam int          ITEMS_PER_PHASE = 45;
   localparam int          RANDOM_PHASES   = 5;
   localparam int          DRAIN_CYCLES    = 16;
   localparam int          HOLD_CYCLES     = 500;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [63:0]                   req_tdata  = '0;   // coefficient, point
   logic                          req_tlast  = 1'b0; // last_coef
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [31:0]                   rsp_tdata;         // derivative_value
   logic [hde_pkg::ORD_W-1:0]     rsp_tuser;         // derivative_order
   logic                          rsp_tlast;         // last
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [hde_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]                   csr_data   = '0;

   logic                          idling_on  = 1'b1;
   logic                          rsp_hold   = 1'b0;
   int unsigned                   cycle_count = 0;
   hde_tb_pkg::horner_scoreboard  sb;

   always #10 clock = ~clock;

   horner_derivative_evaluator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // offer one coefficient, maybe after a gap, and note it once the transfer happens
   // valid stays high on return so back-to-back items need no second assignment
   task automatic send_coef(input logic [31:0] coef, input logic [31:0] point,
                            input logic last_coef);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {point, coef};
      req_tlast  <= last_coef;
      do @(posedge clock); while (!req_tready);
      sb.take_coefficient(coef, point, last_coef);
   endtask

   // csr_valid is left high; the caller drops it after its last write
   task automatic write_csr(input logic [hde_pkg::CSR_IDX_W-1:0] index,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, data);
   endtask

   // registers only change with the block idle: every run closed and all results back
   task automatic settle_and_configure(input logic [hde_pkg::ORD_W-1:0] order,
                                       input logic [31:0] scale);
      logic [31:0] order_word;
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      // upper bits of the order word are junk that must be dropped
      order_word = $urandom;
      order_word[hde_pkg::ORD_W-1:0] = order;
      write_csr(hde_pkg::REG_MAX_DERIVATIVE, order_word);
      write_csr(hde_pkg::REG_INV_SCALE, scale);
      write_csr(REG_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   // result side: check every transfer, then pick ready for the next edge
   initial begin : rsp_side
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_derivative(rsp_tdata, rsp_tuser, rsp_tlast);
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 8) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int                        phase, sent, len, i;
      logic [hde_pkg::ORD_W-1:0] order;
      logic [31:0]               scale, point, coef;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // reset settings: value only, unit scale
      send_coef(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);   // constant-only polynomial
      send_coef(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);   // extreme point on first transfer
      send_coef(32'h0001_0000, 32'h0000_0000, 1'b0);
      send_coef(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

      // all orders, point 1.5, coefficients of every sign and size
      settle_and_configure(3'd7, 32'h0001_0000);
      send_coef(32'h0001_0000, 32'h0001_8000, 1'b0);
      send_coef(32'hFFFE_0000, 32'h0000_0000, 1'b0);
      send_coef(32'h0003_0000, 32'h0000_0000, 1'b0);
      send_coef(32'h0000_8000, 32'h0000_0000, 1'b0);
      send_coef(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
      send_coef(32'h8000_0000, 32'h0000_0000, 1'b0);
      send_coef(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_coef(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      // largest point and coefficients drive orders 0 to 2 into saturation
      send_coef(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_coef(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
      send_coef(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
      // constant-only at full order: all derivatives zero
      send_coef(32'h1234_5678, 32'hFFFF_FFFF, 1'b1);

      // zero inv_scale: scaled point and every derivative above order 0 collapse to zero
      settle_and_configure(3'd3, 32'h0000_0000);
      send_coef(32'h0002_0000, 32'h0002_0000, 1'b0);
      send_coef(32'hFFFF_0000, 32'h0000_0000, 1'b0);
      send_coef(32'h0000_4000, 32'h0000_0000, 1'b1);

      // largest inv_scale, point -1.0
      settle_and_configure(3'd7, 32'hFFFF_FFFF);
      send_coef(32'h0001_0000, 32'hFFFF_0000, 1'b0);
      send_coef(32'h0001_0000, 32'h0000_0000, 1'b0);
      send_coef(32'hFFFF_8000, 32'h0000_0000, 1'b0);
      send_coef(32'h0000_0100, 32'h0000_0000, 1'b1);

      // smallest nonzero inv_scale
      settle_and_configure(3'd5, 32'h0000_0001);
      send_coef(32'h4000_0000, 32'h7FFF_0000, 1'b0);
      send_coef(32'hC000_0000, 32'h0000_0000, 1'b1);

      // ---- random part ----
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         order = $urandom_range(0, 7);
         case ($urandom_range(0, 9))
            0, 1, 2: scale = 32'h0001_0000;
            7:       scale = $urandom;
            8:       scale = 32'hFFFF_FFFF;
            9:       scale = 32'h0000_0000;
            default: scale = $urandom_range(32'h0000_8000, 32'h0002_0000);
         endcase
         settle_and_configure(order, scale);
         if (phase == RANDOM_PHASES - 1)
            idling_on <= 1'b0;   // last stretch runs at full rate
         if (phase == 1) begin
            // long receiver hold-off: the block fills up and stalls its input
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            // mostly points within +-2.0, sometimes anything
            if ($urandom_range(0, 3) == 0)
               point = $urandom;
            else
               point = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 3) == 0)
                  coef = $urandom;
               else
                  coef = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
               // point of later transfers is ignored, so it carries noise
               send_coef(coef, (i == 0) ? point : $urandom, i == len - 1);
            end
            sent += len;
         end
      end

      // ---- drain ----
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8 * 7 + 32) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
src/hde_pkg.sv
src/hde_cell.sv
src/horner_derivative_evaluator_core.sv
tb/hde_tb_pkg.sv
tb/tb_top.sv
